### sv/mlqs_pkg.sv
package mlqs_pkg;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SUBMIT = 2'd0;
    localparam kind_t KIND_SLICE  = 2'd1;
    localparam kind_t KIND_AGE    = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;

    localparam logic [7:0] AGE_MAX      = 8'hFF;
    localparam logic [5:0] PROMO_MAX    = 6'h3F;
    localparam logic [7:0] THRESH_RESET = 8'd5;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  task_id;
        logic [15:0] burst;
        logic [1:0]  level;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic [1:0]  run_level;
        logic        finished;
        logic [15:0] remaining;
        logic [5:0]  promoted_count;
        logic        promote_blocked;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] burst;
        logic [7:0]  age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/mlqs_chan_if.sv
interface mlqs_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/mlqs_ram.sv
module mlqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/multilevel_queue_scheduler_aging.sv
// Channel | Dir | Payload | Accepted when
// cmd     | in  | cmd_t   | cmd.valid && cmd.ready
// rsp     | out | rsp_t   | rsp.valid && rsp.ready
// cfg     | in  | 8 bit   | cfg_we high
//
// Submit writes its entry on acceptance; slice reads the head, then writes back.
// An aging tick does one RAM read and one RAM write per queued task,
// all through the single queue memory.
// Reset empties every level; memory contents need no clearing.
// A held result blocks only the final step of the next item.
module multilevel_queue_scheduler_aging
    import mlqs_pkg::*;
#(
    parameter int LEVEL_COUNT = 3,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_wdata,
    mlqs_chan_if.sink                 cmd,
    mlqs_chan_if.source               rsp
);

    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = $clog2(LEVEL_COUNT);
    localparam int DEPTH = LEVEL_COUNT * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] QD_C  = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] QD_A  = AW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] LV_TOP = LW'(LEVEL_COUNT - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SL_WR = 3'd1;
    localparam logic [2:0] S_AG_RD = 3'd2;
    localparam logic [2:0] S_AG_WR = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] head_reg [LEVEL_COUNT];
    logic [SW-1:0] head_next [LEVEL_COUNT];
    logic [CW-1:0] cnt_reg [LEVEL_COUNT];
    logic [CW-1:0] cnt_next [LEVEL_COUNT];
    logic [LW-1:0] lv_reg, lv_next;
    logic [CW-1:0] j_reg, j_next, k_reg, k_next, n_reg, n_next;
    logic [7:0]    thr_reg;
    rsp_t          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg, out_data_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    mlqs_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] lv,
                                             input logic [SW-1:0] slot);
        return AW'(lv) * QD_A + AW'(slot);
    endfunction

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    logic          accept;
    logic          found;
    logic [LW-1:0] sel_lv;
    logic [LW-1:0] sub_lv;
    logic [LW-1:0] up_lv;
    logic [15:0]   dec_burst;
    logic [7:0]    inc_age;
    logic          promote_try;

    assign accept = cmd.valid && cmd.ready;
    assign sub_lv = LW'(cmd.data.level);
    assign up_lv  = lv_reg - LW'(1);
    assign dec_burst = (ram_rdata.burst != 16'd0) ? ram_rdata.burst - 16'd1 : 16'd0;
    assign inc_age   = (ram_rdata.age != AGE_MAX) ? ram_rdata.age + 8'd1 : AGE_MAX;
    assign promote_try = (lv_reg != '0) && (inc_age > thr_reg);

    always_comb
    begin
        found  = 1'b0;
        sel_lv = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                found  = 1'b1;
                sel_lv = LW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        lv_next        = lv_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_FIN;
                    unique case (cmd.data.kind)
                        KIND_SUBMIT:
                        begin
                            if (int'(cmd.data.level) >= LEVEL_COUNT
                                || cnt_reg[sub_lv] == QD_C)
                            begin
                                res_next.status = STAT_REJECT;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = addr_of(sub_lv,
                                    slot_add(head_reg[sub_lv], cnt_reg[sub_lv]));
                                ram_wdata = '{task_id: cmd.data.task_id,
                                              burst: cmd.data.burst, age: 8'd0};
                                cnt_next[sub_lv] = cnt_reg[sub_lv] + CW'(1);
                            end
                        end
                        KIND_SLICE:
                        begin
                            if (!found)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = addr_of(sel_lv, head_reg[sel_lv]);
                                lv_next    = sel_lv;
                                state_next = S_SL_WR;
                            end
                        end
                        KIND_AGE:
                        begin
                            lv_next    = '0;
                            j_next     = '0;
                            k_next     = '0;
                            n_next     = cnt_reg[0];
                            state_next = S_AG_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SL_WR:
            begin
                res_next.run_id    = ram_rdata.task_id;
                res_next.run_level = 2'(lv_reg);
                res_next.remaining = dec_burst;
                head_next[lv_reg]  = slot_add(head_reg[lv_reg], CW'(1));
                if (dec_burst != 16'd0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_of(lv_reg,
                        slot_add(head_reg[lv_reg], cnt_reg[lv_reg]));
                    ram_wdata = '{task_id: ram_rdata.task_id, burst: dec_burst,
                                  age: ram_rdata.age};
                end
                else
                begin
                    res_next.finished = 1'b1;
                    cnt_next[lv_reg]  = cnt_reg[lv_reg] - CW'(1);
                end
                state_next = S_FIN;
            end
            S_AG_RD:
            begin
                if (j_reg == n_reg)
                begin
                    cnt_next[lv_reg] = k_reg;
                    if (lv_reg == LV_TOP)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        lv_next = lv_reg + LW'(1);
                        n_next  = cnt_reg[lv_reg + LW'(1)];
                        j_next  = '0;
                        k_next  = '0;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_of(lv_reg, slot_add(head_reg[lv_reg], j_reg));
                    state_next = S_AG_WR;
                end
            end
            S_AG_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{task_id: ram_rdata.task_id, burst: ram_rdata.burst,
                              age: inc_age};
                if (promote_try && cnt_reg[up_lv] != QD_C)
                begin
                    ram_waddr = addr_of(up_lv,
                        slot_add(head_reg[up_lv], cnt_reg[up_lv]));
                    cnt_next[up_lv] = cnt_reg[up_lv] + CW'(1);
                    if (res_reg.promoted_count != PROMO_MAX)
                    begin
                        res_next.promoted_count = res_reg.promoted_count + 6'd1;
                    end
                end
                else
                begin
                    if (promote_try)
                    begin
                        res_next.promote_blocked = 1'b1;
                    end
                    ram_waddr = addr_of(lv_reg, slot_add(head_reg[lv_reg], k_reg));
                    k_next    = k_reg + CW'(1);
                end
                j_next     = j_reg + CW'(1);
                state_next = S_AG_RD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= THRESH_RESET;
            lv_reg        <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lv_reg        <= lv_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    for (genvar g = 0; g < LEVEL_COUNT; g++)
    begin : g_chk
        a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
            cnt_reg[g] <= QD_C)
            else $error("level count above depth");
    end

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AG_RD || state_reg == S_AG_WR)
            |-> (k_reg <= j_reg && j_reg <= n_reg))
        else $error("aging walk indexes out of order");

    a_wr_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AG_WR |=> state_reg == S_AG_RD)
        else $error("aging write not followed by read");

    a_slice_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SL_WR |=> state_reg == S_FIN)
        else $error("slice write back did not finish");

endmodule
